/* rtl/pcpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpd_pkg
// Shared widths, register indexes, the coefficient struct and the beat type
// for the point to conic distance block.
// ----------------------------------------------------------------------------
package pcpd_pkg;

   localparam int X_W       = 16;  // Q12.4 coordinate
   localparam int C_W       = 32;  // Q8.24 coefficient
   localparam int P_W       = X_W + C_W;       // coefficient times coordinate
   localparam int T_W       = 49;  // gradient rows, Q.28
   localparam int M_W       = T_W - 1;         // gradient magnitude
   localparam int H_W       = M_W / 2;         // half of a magnitude
   localparam int XT_W      = X_W + H_W + 1;   // coordinate times half row
   localparam int F_W       = 68;  // conic form, Q.32
   localparam int FM_W      = 64;  // magnitude of the form once in range
   localparam int G_W       = 98;  // gradient norm squared, Q.56
   localparam int N_W       = 2 * FM_W;        // form squared
   localparam int Q_W       = 32;  // Q16.16 quotient
   localparam int R_W       = G_W + Q_W;       // partial remainder
   localparam int NUM_CELLS = Q_W;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_XX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_XY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_XW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_YY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_YW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_WW = 3'd5;

   localparam logic [Q_W-1:0] DIST_MAX = '1;

   typedef struct packed {
      logic [C_W-1:0] xx;
      logic [C_W-1:0] xy;
      logic [C_W-1:0] xw;
      logic [C_W-1:0] yy;
      logic [C_W-1:0] yw;
      logic [C_W-1:0] ww;
   } coef_type;

   // one beat travelling down the divider row
   typedef struct packed {
      logic           valid;
      logic [R_W-1:0] rem;
      logic [G_W-1:0] den;
      logic [Q_W-1:0] quo;
      logic           zero;
      logic           sat;
   } div_type;

endpackage

/* rtl/point_conic_polar_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_conic_polar_distance
// Sampson style distance of an image point to a conic, unsigned Q16.16.
//
// Usage:
//  - Load the six Q8.24 conic coefficients through the csr_ write port
//    (index 0..5, others ignored) while no point is in flight.
//  - Points enter on req_ (valid/ready), results leave on rsp_ (valid/ready),
//    one result beat per point, in order.
//  - The path from the accepting edge to rsp_valid runs through eight front
//    stages (products split into operands of at most 32 bits) and a row of
//    32 divider cells, one quotient bit per cell, then the output register.
//  - One point per cycle while req_ready is high; every stage moves together.
//  - A stalled receiver keeps the result in the output register; one more
//    beat lands in the skid register, after which req_ready drops until the
//    skid register drains.
//  - Synchronous reset empties the pipeline and clears the coefficients.
//  - A zero gradient gives all ones with rsp_zero_denominator; an oversized
//    quotient gives all ones with rsp_saturated.
// ----------------------------------------------------------------------------
module point_conic_polar_distance (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [15:0]                        req_x_coord,
   input  logic [15:0]                        req_y_coord,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [31:0]                        rsp_distance,
   output logic                               rsp_zero_denominator,
   output logic                               rsp_saturated,
   input  logic                               csr_write_enable,
   input  logic [pcpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_write_data
);

   localparam int Q_W = pcpd_pkg::Q_W;

   pcpd_pkg::coef_type coef_ff;
   pcpd_pkg::div_type  chain [0:pcpd_pkg::NUM_CELLS];

   logic           en;
   logic           out_v_ff, skid_v_ff, take, new_v;
   logic [Q_W-1:0] out_d_ff, skid_d_ff, new_d;
   logic           out_z_ff, skid_z_ff, new_z;
   logic           out_s_ff, skid_s_ff, new_s;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pcpd_pkg::CSR_COEF_XX: coef_ff.xx <= csr_write_data;
            pcpd_pkg::CSR_COEF_XY: coef_ff.xy <= csr_write_data;
            pcpd_pkg::CSR_COEF_XW: coef_ff.xw <= csr_write_data;
            pcpd_pkg::CSR_COEF_YY: coef_ff.yy <= csr_write_data;
            pcpd_pkg::CSR_COEF_YW: coef_ff.yw <= csr_write_data;
            pcpd_pkg::CSR_COEF_WW: coef_ff.ww <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign en        = !skid_v_ff;
   assign req_ready = en;

   pcpd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_x     (req_x_coord),
      .in_y     (req_y_coord),
      .coef     (coef_ff),
      .out_beat (chain[0])
   );

   for (genvar i = 0; i < pcpd_pkg::NUM_CELLS; i++) begin : g_cell
      pcpd_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_beat  (chain[i]),
         .out_beat (chain[i+1])
      );
   end

   always_comb begin
      new_v = en && chain[pcpd_pkg::NUM_CELLS].valid;
      new_z = chain[pcpd_pkg::NUM_CELLS].zero;
      new_s = chain[pcpd_pkg::NUM_CELLS].sat && !new_z;
      new_d = (new_z || new_s) ? pcpd_pkg::DIST_MAX : chain[pcpd_pkg::NUM_CELLS].quo;
      take  = out_v_ff && rsp_ready;
   end

   // output register with one skid slot
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            skid_v_ff <= 1'b0;
         end
      end else if (new_v) begin
         if (!out_v_ff || take) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take) begin
            out_d_ff <= skid_d_ff;
            out_z_ff <= skid_z_ff;
            out_s_ff <= skid_s_ff;
         end
      end else if (new_v) begin
         if (!out_v_ff || take) begin
            out_d_ff <= new_d;
            out_z_ff <= new_z;
            out_s_ff <= new_s;
         end else begin
            skid_d_ff <= new_d;
            skid_z_ff <= new_z;
            skid_s_ff <= new_s;
         end
      end
   end

   assign rsp_valid            = out_v_ff;
   assign rsp_distance         = out_d_ff;
   assign rsp_zero_denominator = out_z_ff;
   assign rsp_saturated        = out_s_ff;

endmodule

/* rtl/pcpd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpd_front
// Eight stage pipeline: gradient rows, conic form, gradient norm, form
// squared and the range checks that feed the divider row.
// ----------------------------------------------------------------------------
module pcpd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [pcpd_pkg::X_W-1:0]       in_x,
   input  logic [pcpd_pkg::X_W-1:0]       in_y,
   input  pcpd_pkg::coef_type             coef,
   output pcpd_pkg::div_type              out_beat
);

   localparam int X_W  = pcpd_pkg::X_W;
   localparam int P_W  = pcpd_pkg::P_W;
   localparam int T_W  = pcpd_pkg::T_W;
   localparam int M_W  = pcpd_pkg::M_W;
   localparam int H_W  = pcpd_pkg::H_W;
   localparam int XT_W = pcpd_pkg::XT_W;
   localparam int F_W  = pcpd_pkg::F_W;
   localparam int FM_W = pcpd_pkg::FM_W;
   localparam int G_W  = pcpd_pkg::G_W;
   localparam int N_W  = pcpd_pkg::N_W;
   localparam int R_W  = pcpd_pkg::R_W;
   localparam int HF_W = FM_W / 2;

   logic [6:0] v_ff;

   // stage 1
   logic signed [X_W-1:0] x1_ff, y1_ff;
   logic signed [P_W-1:0] pxx_ff, pxyy_ff, pxyx_ff, pyy_ff, pxw_ff, pyw_ff;
   // stage 2
   logic signed [X_W-1:0] x2_ff, y2_ff;
   logic signed [T_W-1:0] t1_ff, t2_ff, t3_ff;
   logic signed [T_W-1:0] t1_in, t2_in, t3_in;
   // stage 3
   logic signed [XT_W-1:0] xh_ff, xl_ff, yh_ff, yl_ff;
   logic signed [T_W-1:0]  t3b_ff;
   logic [M_W-1:0]         m1_ff, m2_ff;
   // stage 4
   logic signed [F_W-1:0]  f_ff, f_in;
   logic [2*H_W-1:0]       s1hh_ff, s1hl_ff, s1ll_ff, s2hh_ff, s2hl_ff, s2ll_ff;
   // stage 5
   logic [G_W-1:0]         g5_ff, g_in;
   logic [F_W-1:0]         fm_in;
   logic [FM_W-1:0]        fm_ff;
   logic                   big5_ff;
   // stage 6
   logic [G_W-1:0]         g6_ff;
   logic                   big6_ff;
   logic [FM_W-1:0]        paa_ff, pab_ff, pbb_ff;
   // stage 7
   logic [G_W-1:0]         g7_ff;
   logic                   big7_ff;
   logic [N_W-1:0]         num_ff, num_in;
   // stage 8
   pcpd_pkg::div_type      out_ff, out_in;

   function automatic logic signed [T_W-1:0] coef_w(input logic [pcpd_pkg::C_W-1:0] c);
      coef_w = $signed({{(T_W - pcpd_pkg::C_W - 4){c[pcpd_pkg::C_W-1]}}, c, 4'b0000});
   endfunction

   always_comb begin
      t1_in = T_W'(pxx_ff) + T_W'(pxyy_ff) + coef_w(coef.xw);
      t2_in = T_W'(pxyx_ff) + T_W'(pyy_ff) + coef_w(coef.yw);
      t3_in = T_W'(pxw_ff) + T_W'(pyw_ff) + coef_w(coef.ww);

      f_in = (F_W'(xh_ff) <<< H_W) + F_W'(xl_ff)
           + (F_W'(yh_ff) <<< H_W) + F_W'(yl_ff)
           + (F_W'(t3b_ff) <<< 4);

      g_in = (G_W'(s1hh_ff) << (2 * H_W)) + (G_W'(s1hl_ff) << (H_W + 1)) + G_W'(s1ll_ff)
           + (G_W'(s2hh_ff) << (2 * H_W)) + (G_W'(s2hl_ff) << (H_W + 1)) + G_W'(s2ll_ff);
      fm_in = f_ff[F_W-1] ? F_W'(-f_ff) : f_ff;

      num_in = (N_W'(paa_ff) << FM_W) + (N_W'(pab_ff) << (HF_W + 1)) + N_W'(pbb_ff);

      out_in.valid = v_ff[6];
      out_in.den   = g7_ff;
      out_in.quo   = '0;
      out_in.zero  = (g7_ff == '0);
      out_in.sat   = big7_ff || (num_ff >= N_W'({g7_ff, 24'b0}));
      // a quotient in range keeps the scaled numerator below the remainder width
      out_in.rem   = R_W'({num_ff, 8'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff   <= $signed(in_x);
         y1_ff   <= $signed(in_y);
         pxx_ff  <= $signed(coef.xx) * $signed(in_x);
         pxyy_ff <= $signed(coef.xy) * $signed(in_y);
         pxyx_ff <= $signed(coef.xy) * $signed(in_x);
         pyy_ff  <= $signed(coef.yy) * $signed(in_y);
         pxw_ff  <= $signed(coef.xw) * $signed(in_x);
         pyw_ff  <= $signed(coef.yw) * $signed(in_y);

         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         t1_ff <= t1_in;
         t2_ff <= t2_in;
         t3_ff <= t3_in;

         // split each row into a signed upper half and an unsigned lower half
         xh_ff  <= x2_ff * $signed(t1_ff[T_W-1:H_W]);
         xl_ff  <= x2_ff * $signed({1'b0, t1_ff[H_W-1:0]});
         yh_ff  <= y2_ff * $signed(t2_ff[T_W-1:H_W]);
         yl_ff  <= y2_ff * $signed({1'b0, t2_ff[H_W-1:0]});
         t3b_ff <= t3_ff;
         m1_ff  <= t1_ff[T_W-1] ? M_W'(-t1_ff) : t1_ff[M_W-1:0];
         m2_ff  <= t2_ff[T_W-1] ? M_W'(-t2_ff) : t2_ff[M_W-1:0];

         f_ff    <= f_in;
         s1hh_ff <= m1_ff[M_W-1:H_W] * m1_ff[M_W-1:H_W];
         s1hl_ff <= m1_ff[M_W-1:H_W] * m1_ff[H_W-1:0];
         s1ll_ff <= m1_ff[H_W-1:0] * m1_ff[H_W-1:0];
         s2hh_ff <= m2_ff[M_W-1:H_W] * m2_ff[M_W-1:H_W];
         s2hl_ff <= m2_ff[M_W-1:H_W] * m2_ff[H_W-1:0];
         s2ll_ff <= m2_ff[H_W-1:0] * m2_ff[H_W-1:0];

         g5_ff   <= g_in;
         fm_ff   <= fm_in[FM_W-1:0];
         big5_ff <= |fm_in[F_W-1:FM_W];

         g6_ff   <= g5_ff;
         big6_ff <= big5_ff;
         paa_ff  <= fm_ff[FM_W-1:HF_W] * fm_ff[FM_W-1:HF_W];
         pab_ff  <= fm_ff[FM_W-1:HF_W] * fm_ff[HF_W-1:0];
         pbb_ff  <= fm_ff[HF_W-1:0] * fm_ff[HF_W-1:0];

         g7_ff   <= g6_ff;
         big7_ff <= big6_ff;
         num_ff  <= num_in;
      end
   end

   assign out_beat = out_ff;

endmodule

/* rtl/pcpd_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpd_div_cell
// One restoring division step: settle one quotient bit and hand the
// shifted remainder to the next cell.
// ----------------------------------------------------------------------------
module pcpd_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  pcpd_pkg::div_type in_beat,
   output pcpd_pkg::div_type out_beat
);

   localparam int R_W = pcpd_pkg::R_W;
   localparam int Q_W = pcpd_pkg::Q_W;

   pcpd_pkg::div_type beat_ff, beat_in;
   logic [R_W:0]      trial;
   logic [R_W-1:0]    nrem;
   logic              ge;

   always_comb begin
      trial = {1'b0, in_beat.rem} - {2'b00, in_beat.den, (Q_W - 1)'(0)};
      ge    = !trial[R_W];
      nrem  = ge ? trial[R_W-1:0] : in_beat.rem;

      beat_in     = in_beat;
      beat_in.rem = {nrem[R_W-2:0], 1'b0};
      beat_in.quo = {in_beat.quo[Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else if (en) begin
         beat_ff <= beat_in;
      end
   end

   assign out_beat = beat_ff;

endmodule
